// ===== rtl/core/mr_pkg.sv =====
// Shared types and constants for the Miller-Rabin round block.
// Control word layout, datapath flags, verdict codes and widths.
// No dependencies.
package mr_pkg;

    localparam int NUM_WIDTH  = 62;
    localparam int WORD_WIDTH = 31;
    // multiplier operand width: wide enough for a candidate and for a random word
    localparam int MUL_Y_WIDTH = (NUM_WIDTH > WORD_WIDTH) ? NUM_WIDTH : WORD_WIDTH;
    // trailing-zero count of n-1 stays below NUM_WIDTH
    localparam int K_WIDTH = $clog2(NUM_WIDTH);
    localparam int PC_WIDTH = 5;

    localparam logic [1:0] VERDICT_COMPOSITE = 2'd0;
    localparam logic [1:0] VERDICT_PROBABLE  = 2'd1;
    localparam logic [1:0] VERDICT_PRIME     = 2'd2;

    typedef logic [PC_WIDTH-1:0] t_pc;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_BASE,
        OP_HALVE,
        OP_MUL_RB,
        OP_SQ_B,
        OP_SETV,
        OP_SQ_V,
        OP_EMIT_COMP,
        OP_EMIT_PASS,
        OP_EMIT_PRIME
    } t_op;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOT_VALID,
        C_N_TWO,
        C_N_BAD,
        C_Q_ODD,
        C_E_ZERO,
        C_E_EVEN,
        C_R_PASS,
        C_I_DONE,
        C_V_NM1
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_ctrl;

    typedef struct packed {
        logic step_done;
        logic in_valid;
        logic n_two;
        logic n_bad;
        logic q_odd;
        logic e_zero;
        logic e_even;
        logic r_pass;
        logic i_done;
        logic v_nm1;
    } t_flags;

endpackage

// ===== rtl/core/mr_modmul.sv =====
// Serial modular multiplier: (x * y) mod m by double-and-add, one bit of y per cycle.
// Depends on mr_pkg.
module mr_modmul (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [mr_pkg::NUM_WIDTH-1:0]      i_x,
    input  logic [mr_pkg::MUL_Y_WIDTH-1:0]    i_y,
    input  logic [mr_pkg::NUM_WIDTH-1:0]      i_m,
    output logic                              o_done,
    output logic [mr_pkg::NUM_WIDTH-1:0]      o_prod
);

    logic                              r_busy;
    logic [mr_pkg::NUM_WIDTH-1:0]      r_x;
    logic [mr_pkg::MUL_Y_WIDTH-1:0]    r_y;
    logic [mr_pkg::NUM_WIDTH-1:0]      r_acc;
    logic [mr_pkg::NUM_WIDTH-1:0]      r_m;

    logic [mr_pkg::NUM_WIDTH:0]        acc_sum;
    logic [mr_pkg::NUM_WIDTH:0]        x_dbl;
    logic [mr_pkg::NUM_WIDTH-1:0]      n_acc;
    logic [mr_pkg::NUM_WIDTH-1:0]      n_x;

    // operands stay below m, so one conditional subtract reduces each sum
    always_comb begin
        acc_sum = {1'b0, r_acc} + {1'b0, r_x};
        x_dbl   = {r_x, 1'b0};
        if (acc_sum >= {1'b0, r_m}) begin
            acc_sum = acc_sum - {1'b0, r_m};
        end
        if (x_dbl >= {1'b0, r_m}) begin
            x_dbl = x_dbl - {1'b0, r_m};
        end
        n_acc = r_y[0] ? acc_sum[mr_pkg::NUM_WIDTH-1:0] : r_acc;
        n_x   = x_dbl[mr_pkg::NUM_WIDTH-1:0];
    end

    assign o_done = r_busy && (r_y == '0);
    assign o_prod = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_m   <= i_m;
            r_acc <= '0;
        end else if (r_busy && (r_y != '0)) begin
            r_acc <= n_acc;
            r_x   <= n_x;
            r_y   <= r_y >> 1;
        end
    end

endmodule

// ===== rtl/core/mr_datapath.sv =====
// Datapath of the Miller-Rabin round: operand registers, the shared serial
// multiplier, the output word register and the flags the sequencer tests.
// Depends on mr_pkg and mr_modmul.
module mr_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mr_pkg::t_ctrl                    i_ctrl,
    input  logic                             i_in_valid,
    input  logic [mr_pkg::NUM_WIDTH-1:0]     i_candidate,
    input  logic [mr_pkg::WORD_WIDTH-1:0]    i_random_word,
    input  logic                             i_out_stall,
    output mr_pkg::t_flags                   o_flags,
    output logic                             o_in_stall,
    output logic                             o_out_valid,
    output logic [1:0]                       o_verdict
);

    localparam int W  = mr_pkg::NUM_WIDTH;
    localparam int YW = mr_pkg::MUL_Y_WIDTH;
    localparam int KW = mr_pkg::K_WIDTH;

    logic [W-1:0]                     r_n;
    logic [mr_pkg::WORD_WIDTH-1:0]    r_word;
    logic [W-1:0]                     r_q;     // q during split, then the exponent
    logic [KW-1:0]                    r_k;
    logic [KW-1:0]                    r_i;
    logic [W-1:0]                     r_base;
    logic [W-1:0]                     r_r;
    logic [W-1:0]                     r_v;
    logic                             r_run;
    logic                             r_out_valid;
    logic [1:0]                       r_verdict;

    logic             is_mul;
    logic             mm_start;
    logic             mm_done;
    logic [W-1:0]     mm_prod;
    logic [W-1:0]     mm_x;
    logic [YW-1:0]    mm_y;
    logic [W-1:0]     mm_m;
    logic [W-1:0]     n_minus1;
    logic             accept;
    logic             emit_ok;
    logic             is_emit;
    logic             mul_fin;
    logic             step_done;

    assign n_minus1 = r_n - W'(1);
    assign is_mul   = (i_ctrl.op == mr_pkg::OP_BASE) || (i_ctrl.op == mr_pkg::OP_MUL_RB) ||
                      (i_ctrl.op == mr_pkg::OP_SQ_B) || (i_ctrl.op == mr_pkg::OP_SQ_V);
    assign is_emit  = (i_ctrl.op == mr_pkg::OP_EMIT_COMP) ||
                      (i_ctrl.op == mr_pkg::OP_EMIT_PASS) ||
                      (i_ctrl.op == mr_pkg::OP_EMIT_PRIME);
    assign mm_start = is_mul && !r_run;
    assign mul_fin  = is_mul && r_run && mm_done;
    assign emit_ok  = !r_out_valid || !i_out_stall;
    assign accept   = (i_ctrl.op == mr_pkg::OP_ACCEPT) && i_in_valid;

    assign o_in_stall  = (i_ctrl.op != mr_pkg::OP_ACCEPT) || !i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;

    always_comb begin
        mm_x = r_r;
        mm_y = YW'(r_base);
        mm_m = r_n;
        case (i_ctrl.op)
            mr_pkg::OP_BASE: begin
                // word mod (n-1) as 1 * word mod (n-1)
                mm_x = W'(1);
                mm_y = YW'(r_word);
                mm_m = n_minus1;
            end
            mr_pkg::OP_MUL_RB: begin
                mm_x = r_r;
                mm_y = YW'(r_base);
            end
            mr_pkg::OP_SQ_B: begin
                mm_x = r_base;
                mm_y = YW'(r_base);
            end
            mr_pkg::OP_SQ_V: begin
                mm_x = r_v;
                mm_y = YW'(r_v);
            end
            default: begin
                mm_x = r_r;
            end
        endcase
    end

    always_comb begin
        if (is_mul) begin
            step_done = mul_fin;
        end else if (is_emit) begin
            step_done = emit_ok;
        end else begin
            step_done = 1'b1;
        end
    end

    mr_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mm_start),
        .i_x     (mm_x),
        .i_y     (mm_y),
        .i_m     (mm_m),
        .o_done  (mm_done),
        .o_prod  (mm_prod)
    );

    always_comb begin
        o_flags.step_done = step_done;
        o_flags.in_valid  = i_in_valid;
        o_flags.n_two     = (r_n == W'(2));
        o_flags.n_bad     = (r_n <= W'(1)) || !r_n[0];
        o_flags.q_odd     = r_q[0];
        o_flags.e_zero    = (r_q == '0);
        o_flags.e_even    = !r_q[0];
        o_flags.r_pass    = (r_r == W'(1)) || (r_r == n_minus1);
        o_flags.i_done    = (r_i >= r_k);
        o_flags.v_nm1     = (r_v == n_minus1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (mm_start) begin
                r_run <= 1'b1;
            end else if (mul_fin) begin
                r_run <= 1'b0;
            end
            if (is_emit && emit_ok) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_n    <= i_candidate;
            r_word <= i_random_word;
            r_q    <= i_candidate - W'(1);
            r_k    <= '0;
            r_r    <= W'(1);
        end
        case (i_ctrl.op)
            mr_pkg::OP_HALVE: begin
                r_q <= r_q >> 1;
                r_k <= r_k + KW'(1);
            end
            mr_pkg::OP_BASE: begin
                if (mul_fin) begin
                    r_base <= mm_prod + W'(1);
                end
            end
            mr_pkg::OP_MUL_RB: begin
                if (mul_fin) begin
                    r_r <= mm_prod;
                end
            end
            mr_pkg::OP_SQ_B: begin
                if (mul_fin) begin
                    r_base <= mm_prod;
                    r_q    <= r_q >> 1;
                end
            end
            mr_pkg::OP_SETV: begin
                r_v <= r_r;
                r_i <= KW'(1);
            end
            mr_pkg::OP_SQ_V: begin
                if (mul_fin) begin
                    r_v <= mm_prod;
                    r_i <= r_i + KW'(1);
                end
            end
            mr_pkg::OP_EMIT_COMP: begin
                if (emit_ok) begin
                    r_verdict <= mr_pkg::VERDICT_COMPOSITE;
                end
            end
            mr_pkg::OP_EMIT_PASS: begin
                if (emit_ok) begin
                    r_verdict <= mr_pkg::VERDICT_PROBABLE;
                end
            end
            mr_pkg::OP_EMIT_PRIME: begin
                if (emit_ok) begin
                    r_verdict <= mr_pkg::VERDICT_PRIME;
                end
            end
            default: begin
                r_v <= r_v;
            end
        endcase
    end

endmodule

// ===== rtl/core/mr_seq.sv =====
// Microcode sequencer: step counter, control store and jump-condition select.
// Depends on mr_pkg.
module mr_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mr_pkg::t_flags    i_flags,
    output mr_pkg::t_ctrl     o_ctrl
);

    localparam mr_pkg::t_pc S_WAIT  = 5'd0;
    localparam mr_pkg::t_pc S_SPLIT = 5'd4;
    localparam mr_pkg::t_pc S_POW   = 5'd6;
    localparam mr_pkg::t_pc S_SQB   = 5'd9;
    localparam mr_pkg::t_pc S_CHECK = 5'd10;
    localparam mr_pkg::t_pc S_LOOP  = 5'd11;
    localparam mr_pkg::t_pc S_COMP  = 5'd15;
    localparam mr_pkg::t_pc S_PASS  = 5'd16;
    localparam mr_pkg::t_pc S_PRIME = 5'd17;

    function automatic mr_pkg::t_ctrl rom_word(input mr_pkg::t_pc pc);
        mr_pkg::t_ctrl w;
        w = '{op: mr_pkg::OP_NOP, cond: mr_pkg::C_ALWAYS, target: S_WAIT};
        case (pc)
            5'd0:  w = '{op: mr_pkg::OP_ACCEPT,     cond: mr_pkg::C_NOT_VALID, target: S_WAIT};
            5'd1:  w = '{op: mr_pkg::OP_NOP,        cond: mr_pkg::C_N_TWO,     target: S_PRIME};
            5'd2:  w = '{op: mr_pkg::OP_NOP,        cond: mr_pkg::C_N_BAD,     target: S_COMP};
            5'd3:  w = '{op: mr_pkg::OP_BASE,       cond: mr_pkg::C_NEVER,     target: S_WAIT};
            5'd4:  w = '{op: mr_pkg::OP_NOP,        cond: mr_pkg::C_Q_ODD,     target: S_POW};
            5'd5:  w = '{op: mr_pkg::OP_HALVE,      cond: mr_pkg::C_ALWAYS,    target: S_SPLIT};
            5'd6:  w = '{op: mr_pkg::OP_NOP,        cond: mr_pkg::C_E_ZERO,    target: S_CHECK};
            5'd7:  w = '{op: mr_pkg::OP_NOP,        cond: mr_pkg::C_E_EVEN,    target: S_SQB};
            5'd8:  w = '{op: mr_pkg::OP_MUL_RB,     cond: mr_pkg::C_NEVER,     target: S_WAIT};
            5'd9:  w = '{op: mr_pkg::OP_SQ_B,       cond: mr_pkg::C_ALWAYS,    target: S_POW};
            5'd10: w = '{op: mr_pkg::OP_SETV,       cond: mr_pkg::C_R_PASS,    target: S_PASS};
            5'd11: w = '{op: mr_pkg::OP_NOP,        cond: mr_pkg::C_I_DONE,    target: S_COMP};
            5'd12: w = '{op: mr_pkg::OP_SQ_V,       cond: mr_pkg::C_NEVER,     target: S_WAIT};
            5'd13: w = '{op: mr_pkg::OP_NOP,        cond: mr_pkg::C_V_NM1,     target: S_PASS};
            5'd14: w = '{op: mr_pkg::OP_NOP,        cond: mr_pkg::C_ALWAYS,    target: S_LOOP};
            5'd15: w = '{op: mr_pkg::OP_EMIT_COMP,  cond: mr_pkg::C_ALWAYS,    target: S_WAIT};
            5'd16: w = '{op: mr_pkg::OP_EMIT_PASS,  cond: mr_pkg::C_ALWAYS,    target: S_WAIT};
            5'd17: w = '{op: mr_pkg::OP_EMIT_PRIME, cond: mr_pkg::C_ALWAYS,    target: S_WAIT};
            default: w = '{op: mr_pkg::OP_NOP, cond: mr_pkg::C_ALWAYS, target: S_WAIT};
        endcase
        return w;
    endfunction

    mr_pkg::t_pc r_pc;
    mr_pkg::t_pc n_pc;
    logic        take;

    assign o_ctrl = rom_word(r_pc);

    always_comb begin
        case (o_ctrl.cond)
            mr_pkg::C_NEVER:     take = 1'b0;
            mr_pkg::C_ALWAYS:    take = 1'b1;
            mr_pkg::C_NOT_VALID: take = !i_flags.in_valid;
            mr_pkg::C_N_TWO:     take = i_flags.n_two;
            mr_pkg::C_N_BAD:     take = i_flags.n_bad;
            mr_pkg::C_Q_ODD:     take = i_flags.q_odd;
            mr_pkg::C_E_ZERO:    take = i_flags.e_zero;
            mr_pkg::C_E_EVEN:    take = i_flags.e_even;
            mr_pkg::C_R_PASS:    take = i_flags.r_pass;
            mr_pkg::C_I_DONE:    take = i_flags.i_done;
            mr_pkg::C_V_NM1:     take = i_flags.v_nm1;
            default:             take = 1'b0;
        endcase
        if (!i_flags.step_done) begin
            n_pc = r_pc;
        end else if (take) begin
            n_pc = o_ctrl.target;
        end else begin
            n_pc = r_pc + mr_pkg::t_pc'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ===== rtl/core/miller_rabin_round.sv =====
// Miller-Rabin round, top level: microcode sequencer plus datapath.
// Depends on mr_pkg, mr_seq, mr_datapath (and mr_modmul below it).
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one word: a candidate n
//   and a random word. Output channel (o_out_valid / i_out_stall) returns one
//   verdict per input word: 0 composite, 1 passed the round, 2 prime (n = 2).
//   A word is taken only in the sequencer's wait step; the block works on one
//   candidate at a time.
// Timing:
//   Special cases (n < 3 or even) skip the exponentiation. Otherwise the base
//   reduction and every modular multiply run on the single serial multiplier,
//   which sets the rate: for a 62-bit n about 124 multiplies.
//   The verdict lands in an output register; the next input word is taken
//   while it waits. A stalled verdict holds, and the sequencer waits at its
//   emit step only if a new verdict is ready before the old one is taken.
// Reset: synchronous, active low; the sequencer returns to the wait step and
//   the output register empties. No clearing pass is needed.
module miller_rabin_round (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic [mr_pkg::NUM_WIDTH-1:0]     i_candidate,
    input  logic [mr_pkg::WORD_WIDTH-1:0]    i_random_word,
    output logic                             o_in_stall,
    output logic                             o_out_valid,
    output logic [1:0]                       o_verdict,
    input  logic                             i_out_stall
);

    mr_pkg::t_ctrl  ctrl;
    mr_pkg::t_flags flags;

    mr_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctrl)
    );

    mr_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .i_in_valid    (i_in_valid),
        .i_candidate   (i_candidate),
        .i_random_word (i_random_word),
        .i_out_stall   (i_out_stall),
        .o_flags       (flags),
        .o_in_stall    (o_in_stall),
        .o_out_valid   (o_out_valid),
        .o_verdict     (o_verdict)
    );

endmodule

// ===== rtl/core/mr_checker.sv =====
// Port-level checks for miller_rabin_round, bound to the top level.
// Depends on mr_pkg for widths and verdict codes.
module mr_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic [mr_pkg::NUM_WIDTH-1:0]     i_candidate,
    input logic [mr_pkg::WORD_WIDTH-1:0]    i_random_word,
    input logic                             o_in_stall,
    input logic                             o_out_valid,
    input logic [1:0]                       o_verdict,
    input logic                             i_out_stall
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // a waiting input word holds until it is taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=>
            i_in_valid && $stable(i_candidate) && $stable(i_random_word))
        else $error("input word dropped or changed while stalled");

    // a stalled verdict word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_verdict))
        else $error("verdict dropped or changed while stalled");

    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_verdict == mr_pkg::VERDICT_COMPOSITE) ||
                        (o_verdict == mr_pkg::VERDICT_PROBABLE) ||
                        (o_verdict == mr_pkg::VERDICT_PRIME))
        else $error("illegal verdict code");

    // one word in flight: after an accept the input side closes
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("second input word taken while busy");

    // no verdict can be produced in the cycle an input is taken
    a_no_emit_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !$rose(o_out_valid))
        else $error("verdict appeared together with input accept");

endmodule

bind miller_rabin_round mr_checker u_mr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .i_candidate   (i_candidate),
    .i_random_word (i_random_word),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .o_verdict     (o_verdict),
    .i_out_stall   (i_out_stall)
);
